// File: design/pfe_pkg.sv
`timescale 1ns / 1ps
package pfe_pkg;
  localparam int SLOT_COUNT_DEF = 16;
  localparam int PALETTE_ENTRIES_DEF = 512;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_SETUP = 3'd1,
    OP_FREE  = 3'd2,
    OP_START = 3'd3,
    OP_STOP  = 3'd4,
    OP_TICK  = 3'd5,
    OP_READ  = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_RD,
    ST_WAIT,
    ST_WR,
    ST_READ,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_RESTORE,
    RK_FILL,
    RK_FADE
  } range_kind_t;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // One fade step on a single 5-bit field.
  function automatic logic [4:0] fade_field(input logic [4:0] c, input logic [4:0] o,
                                            input logic neg, input logic [1:0] ph);
    logic [5:0] n;
    logic mv;
    begin
      n = neg ? ({1'b0, c} - 6'd1) : ({1'b0, c} + 6'd1);
      mv = 1'b0;
      if (ph == PH_FIRST) begin
        mv = !n[5];
      end else if (ph == PH_SECOND) begin
        mv = neg ? (!n[5] && n[4:0] >= o) : (!n[5] && n[4:0] <= o);
      end
      fade_field = mv ? n[4:0] : c;
    end
  endfunction

  function automatic logic [15:0] fade_color(input logic [15:0] c, input logic [15:0] o,
                                             input logic neg, input logic [1:0] ph);
    begin
      fade_color = {c[15], fade_field(c[14:10], o[14:10], neg, ph),
                    fade_field(c[9:5], o[9:5], neg, ph), fade_field(c[4:0], o[4:0], neg, ph)};
    end
  endfunction
endpackage

// File: design/pfe_palette_mem.sv
`timescale 1ns / 1ps
module pfe_palette_mem #(
  parameter int ENTRIES = pfe_pkg::PALETTE_ENTRIES_DEF,
  parameter int AW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);
  logic [15:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/palette_flash_engine_top.sv
`timescale 1ns / 1ps
// Palette effect engine with up to SLOT_COUNT effect slots over two palettes
// (base and shown) of PALETTE_ENTRIES 16-bit colors, each held in a
// synchronous one-port-write, one-port-read memory.
// The input channel (valid/ready) carries one operation per transfer; every
// operation yields exactly one result transfer on the output channel
// (status, slot_number, read_color).
// Load, setup, free, start and unknown codes go through the slot state to the
// result state. Read adds a read state that captures the registered memory
// data. Stop and tick walk the slots in turn and, for each slot whose range
// is touched, walk its entries, up to 255 per slot (read both palettes, wait
// for the registered read data, write back). The shown-palette
// read-modify-write loop sets the worst case.
// The block takes one operation at a time: ready is high only when no
// operation is in progress and the result register is empty.
// Reset clears all slot state, the state machine and the run state at once.
// The palettes are cleared by a sweep after reset, one entry per cycle over
// all PALETTE_ENTRIES entries, during which no input is accepted.
// When the receiver stalls, the result is held in the output register and
// no new operation is taken until it has been transferred.
module palette_flash_engine_top #(
  parameter int SLOT_COUNT = pfe_pkg::SLOT_COUNT_DEF,
  parameter int PALETTE_ENTRIES = pfe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [15:0] slot_or_mask,
  input  logic [8:0]  palette_index,
  input  logic [15:0] color,
  input  logic [7:0]  entry_count,
  input  logic [7:0]  tick_delay,
  input  logic [4:0]  step_period,
  input  logic        start_negative,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [3:0]  slot_number,
  output logic [15:0] read_color
);
  import pfe_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Per-slot registers.
  logic        s_alloc [SLOT_COUNT];
  logic [15:0] s_color [SLOT_COUNT];
  logic [8:0]  s_first [SLOT_COUNT];
  logic [7:0]  s_len   [SLOT_COUNT];
  logic [7:0]  s_reload[SLOT_COUNT];
  logic [4:0]  s_half  [SLOT_COUNT];
  logic        s_nstart[SLOT_COUNT];
  logic [1:0]  s_phase [SLOT_COUNT];
  logic [7:0]  s_timer [SLOT_COUNT];
  logic [4:0]  s_step  [SLOT_COUNT];
  logic        s_dneg  [SLOT_COUNT];
  logic [15:0] active_slots;
  logic        engine_running;

  state_t state;
  state_t state_next;
  op_t    op;
  logic [15:0] som;
  logic [8:0]  idx;
  logic [15:0] col;
  logic [7:0]  cnt;
  logic [7:0]  dly;
  logic [4:0]  per;
  logic        sneg;
  logic [SW:0] slot;
  logic [7:0]  ent;
  range_kind_t kind;
  logic [AW:0] clr;
  logic        clearing;
  logic        walk_op;

  logic [15:0] shown_rd;
  logic [15:0] base_rd;
  logic        pal_we;
  logic        base_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [15:0] wdata;
  logic [15:0] base_wdata;

  logic        res_status;
  logic [3:0]  res_slot;
  logic [15:0] res_color;

  logic [SW-1:0] cs;
  logic [SW-1:0] som_slot;
  logic          som_ok;
  logic [15:0]   walk_addr;

  assign cs = slot[SW-1:0];
  assign som_ok = (som < 16'(SLOT_COUNT));
  assign som_slot = som[SW-1:0];
  assign clearing = !clr[AW];
  assign in_ready = (state == ST_IDLE) && !clearing && !rst;
  assign walk_addr = 16'(s_first[cs]) + 16'(ent);
  // Stop and tick use cnt and dly as walk bookkeeping, so they start clear.
  assign walk_op = (op_t'(operation) == OP_STOP) || (op_t'(operation) == OP_TICK);

  pfe_palette_mem #(.ENTRIES(PALETTE_ENTRIES), .AW(AW)) u_shown (
    .clk(clk), .we(pal_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(shown_rd)
  );
  pfe_palette_mem #(.ENTRIES(PALETTE_ENTRIES), .AW(AW)) u_base (
    .clk(clk), .we(base_we), .waddr(waddr), .wdata(base_wdata), .raddr(raddr),
    .rdata(base_rd)
  );

  always_comb begin
    pal_we = 1'b0;
    base_we = 1'b0;
    waddr = walk_addr[AW-1:0];
    wdata = shown_rd;
    base_wdata = col;
    raddr = walk_addr[AW-1:0];
    if (clearing) begin
      pal_we = 1'b1;
      base_we = 1'b1;
      waddr = clr[AW-1:0];
      wdata = '0;
      base_wdata = '0;
    end else if (state == ST_IDLE && in_valid && op_t'(operation) == OP_LOAD) begin
      pal_we = 1'b1;
      base_we = 1'b1;
      waddr = AW'(16'(palette_index) % 16'(PALETTE_ENTRIES));
      wdata = color;
      base_wdata = color;
    end else if (state == ST_READ || state == ST_SLOT && op == OP_READ) begin
      raddr = AW'(16'(idx) % 16'(PALETTE_ENTRIES));
    end else if (state == ST_WR) begin
      pal_we = 1'b1;
      unique case (kind)
        RK_RESTORE: wdata = base_rd;
        RK_FILL:    wdata = s_color[cs];
        RK_FADE:    wdata = fade_color(shown_rd, base_rd, s_dneg[cs], s_phase[cs]);
        default:    pal_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_ready && in_valid) state_next = ST_SLOT;
      ST_SLOT: begin
        if (op == OP_READ) state_next = ST_READ;
        else if ((op == OP_STOP || op == OP_TICK) && slot < (SW+1)'(SLOT_COUNT)) begin
          state_next = ST_SLOT;
          if (kind != RK_NONE && cnt != 0) state_next = ST_RD;
        end else state_next = ST_OUT;
      end
      ST_RD:    state_next = ST_WAIT;
      ST_WAIT:  state_next = ST_WR;
      ST_WR:    state_next = ST_SLOT;
      ST_READ:  state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Hidden detail: during ST_SLOT for stop/tick, cnt holds the entries left in
  // the slot's range and kind the pending range action, set on an earlier visit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clr <= '0;
      active_slots <= '0;
      engine_running <= 1'b0;
      slot <= '0;
      kind <= RK_NONE;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        s_alloc[s] <= 1'b0; s_color[s] <= '0; s_first[s] <= '0; s_len[s] <= '0;
        s_reload[s] <= '0; s_half[s] <= '0; s_nstart[s] <= 1'b0; s_phase[s] <= PH_IDLE;
        s_timer[s] <= '0; s_step[s] <= '0; s_dneg[s] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (clearing) clr <= clr + 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (in_ready && in_valid) begin
            op <= op_t'(operation); som <= slot_or_mask; idx <= palette_index;
            col <= color; per <= step_period;
            cnt <= walk_op ? 8'd0 : entry_count;
            dly <= walk_op ? 8'd0 : tick_delay;
            sneg <= start_negative;
            slot <= '0; kind <= RK_NONE; ent <= '0;
            res_status <= 1'b0; res_slot <= '0; res_color <= '0;
          end
        end
        ST_SLOT: begin
          if (op == OP_SETUP) begin
            if (!som_ok || s_alloc[som_slot]) res_status <= 1'b1;
            else begin
              s_color[som_slot] <= col; s_first[som_slot] <= idx; s_len[som_slot] <= cnt;
              s_reload[som_slot] <= dly; s_half[som_slot] <= per;
              s_nstart[som_slot] <= sneg; s_phase[som_slot] <= PH_IDLE;
              s_alloc[som_slot] <= 1'b1; s_step[som_slot] <= '0; s_timer[som_slot] <= '0;
              s_dneg[som_slot] <= sneg; res_slot <= som[3:0];
            end
          end else if (op == OP_FREE) begin
            if (!som_ok || !s_alloc[som_slot]) res_status <= 1'b1;
            else begin
              s_alloc[som_slot] <= 1'b0; s_color[som_slot] <= '0; s_first[som_slot] <= '0;
              s_len[som_slot] <= '0; s_reload[som_slot] <= '0; s_half[som_slot] <= '0;
              s_nstart[som_slot] <= 1'b0; s_phase[som_slot] <= PH_IDLE;
              s_timer[som_slot] <= '0; s_step[som_slot] <= '0; s_dneg[som_slot] <= 1'b0;
              res_slot <= som[3:0];
            end
          end else if (op == OP_START) begin
            engine_running <= 1'b1;
            for (int s = 0; s < SLOT_COUNT; s++) begin
              if (som[s] && s_alloc[s]) begin
                active_slots[s] <= 1'b1;
                s_phase[s] <= PH_FIRST;
              end
            end
          end else if (op == OP_STOP || op == OP_TICK) begin
            if (kind != RK_NONE && cnt != 0) begin
              // Range walk pending for slot; go walk it.
            end else if (slot < (SW+1)'(SLOT_COUNT)) begin
              // Set up this slot's range action, or finish its bookkeeping and move on.
              kind <= RK_NONE;
              ent <= '0;
              if (op == OP_STOP) begin
                if (kind == RK_NONE && active_slots[cs] && s_alloc[cs] && som[cs] &&
                    s_len[cs] != 0 && cnt == 0 && ent == 0 && !dly[0]) begin
                  kind <= RK_RESTORE; cnt <= s_len[cs];
                  dly[0] <= 1'b1;
                end else begin
                  if (active_slots[cs] && s_alloc[cs] && som[cs]) begin
                    s_phase[cs] <= PH_IDLE; s_step[cs] <= '0; s_timer[cs] <= '0;
                    s_dneg[cs] <= s_nstart[cs];
                  end
                  dly[0] <= 1'b0; cnt <= '0;
                  slot <= slot + 1'b1;
                end
              end else begin
                if (!engine_running || !active_slots[cs]) begin
                  slot <= slot + 1'b1;
                  dly[0] <= 1'b0; cnt <= '0;
                end else if (!dly[0]) begin
                  s_timer[cs] <= s_timer[cs] - 1'b1;
                  if (s_timer[cs] == 8'd0) begin
                    dly[0] <= 1'b1;
                    cnt <= s_len[cs];
                    if (s_color[cs][15]) kind <= RK_FADE;
                    else if (s_phase[cs] == PH_FIRST) kind <= RK_FILL;
                    else if (s_phase[cs] == PH_SECOND) kind <= RK_RESTORE;
                  end else slot <= slot + 1'b1;
                end else begin
                  // Step done: update the slot's sequencing state.
                  s_timer[cs] <= s_reload[cs];
                  if (s_color[cs][15]) begin
                    if (s_step[cs] != s_half[cs]) s_step[cs] <= s_step[cs] + 1'b1;
                    else begin
                      s_step[cs] <= '0;
                      s_dneg[cs] <= !s_dneg[cs];
                      s_phase[cs] <= (s_phase[cs] == PH_FIRST) ? PH_SECOND
                                                                : s_phase[cs] - 1'b1;
                    end
                  end else if (s_phase[cs] == PH_FIRST) s_phase[cs] <= PH_SECOND;
                  else if (s_phase[cs] == PH_SECOND) s_phase[cs] <= PH_FIRST;
                  dly[0] <= 1'b0; cnt <= '0;
                  slot <= slot + 1'b1;
                end
              end
            end else if (op == OP_STOP) begin
              if (som == 16'hFFFF) begin
                engine_running <= 1'b0; active_slots <= '0;
              end else active_slots <= active_slots & ~som;
            end
          end
        end
        ST_WR: begin
          ent <= ent + 1'b1;
          cnt <= cnt - 1'b1;
          if (cnt == 8'd1) kind <= RK_NONE;
        end
        ST_READ: res_color <= shown_rd;
        default: ;
      endcase
    end
  end

  assign out_valid = (state == ST_OUT);
  assign status = res_status;
  assign slot_number = res_slot;
  assign read_color = res_color;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_color))
    else $error("result dropped under stall");
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready) else $error("input accepted during clear");
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for palette_flash_engine_top. A queue of operations, filled by
// the stimulus process, feeds a clocked driver. A clocked monitor takes each
// result transfer and compares it with the oldest prediction. Predictions
// come from a behavioral copy of the engine kept in this module.
module tb;
  import pfe_pkg::*;

  localparam int SLOTS = 16;
  localparam int ENTRIES = 512;
  // The idle limit is set well past the longest full tick.
  localparam int IDLE_LIMIT = 100000;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] som;
    logic [8:0]  idx;
    logic [15:0] col;
    logic [7:0]  cnt;
    logic [7:0]  dly;
    logic [4:0]  per;
    logic        neg;
  } engine_cmd_t;

  typedef struct packed {
    logic        st;
    logic [3:0]  slot;
    logic [15:0] rd;
  } engine_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0]  operation = '0;
  logic [15:0] slot_or_mask = '0;
  logic [8:0]  palette_index = '0;
  logic [15:0] color = '0;
  logic [7:0]  entry_count = '0;
  logic [7:0]  tick_delay = '0;
  logic [4:0]  step_period = '0;
  logic        start_negative = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [3:0]  slot_number;
  logic [15:0] read_color;

  palette_flash_engine_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .slot_or_mask(slot_or_mask),
    .palette_index(palette_index), .color(color), .entry_count(entry_count),
    .tick_delay(tick_delay), .step_period(step_period),
    .start_negative(start_negative), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .slot_number(slot_number),
    .read_color(read_color)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: a shadow copy of both palettes and every slot.
  logic [15:0] pal_shown [ENTRIES];
  logic [15:0] pal_base [ENTRIES];
  logic        sl_alloc [SLOTS];
  logic [15:0] sl_color [SLOTS];
  logic [8:0]  sl_first [SLOTS];
  logic [7:0]  sl_len [SLOTS];
  logic [7:0]  sl_reload [SLOTS];
  logic [4:0]  sl_half [SLOTS];
  logic        sl_negstart [SLOTS];
  logic [1:0]  sl_phase [SLOTS];
  logic [7:0]  sl_timer [SLOTS];
  logic [4:0]  sl_steps [SLOTS];
  logic        sl_neg [SLOTS];
  logic [15:0] active_mask;
  logic        running;

  engine_cmd_t  pending_cmds[$];
  engine_resp_t expected_resps[$];
  int errors = 0;
  bit stimulus_done = 1'b0;

  function automatic void clear_slot_model(int s);
    sl_alloc[s] = 0; sl_color[s] = 0; sl_first[s] = 0; sl_len[s] = 0;
    sl_reload[s] = 0; sl_half[s] = 0; sl_negstart[s] = 0; sl_phase[s] = PH_IDLE;
    sl_timer[s] = 0; sl_steps[s] = 0; sl_neg[s] = 0;
  endfunction

  function automatic void restore_model(int s);
    logic [8:0] e;
    for (int i = 0; i < sl_len[s]; i++) begin
      e = sl_first[s] + 9'(i);
      pal_shown[e] = pal_base[e];
    end
  endfunction

  // Fade one 5-bit channel; phase 2 never moves past the base value.
  function automatic logic [4:0] fade_chan(logic [4:0] c, logic [4:0] o, logic neg,
                                          logic [1:0] ph);
    int n;
    bit mv;
    n = neg ? int'(c) - 1 : int'(c) + 1;
    mv = 0;
    if (ph == PH_FIRST) mv = (n >= 0 && n < 32);
    else if (ph == PH_SECOND) mv = neg ? (n >= int'(o)) : (n <= int'(o));
    return mv ? n[4:0] : c;
  endfunction

  function automatic void fade_model(int s);
    logic [8:0] e;
    logic [15:0] c, o;
    for (int i = 0; i < sl_len[s]; i++) begin
      e = sl_first[s] + 9'(i);
      c = pal_shown[e];
      o = pal_base[e];
      pal_shown[e] = {c[15], fade_chan(c[14:10], o[14:10], sl_neg[s], sl_phase[s]),
                      fade_chan(c[9:5], o[9:5], sl_neg[s], sl_phase[s]),
                      fade_chan(c[4:0], o[4:0], sl_neg[s], sl_phase[s])};
    end
    if (sl_steps[s] != sl_half[s]) begin
      sl_steps[s] = sl_steps[s] + 5'd1;
    end else begin
      sl_steps[s] = 0;
      sl_neg[s] = ~sl_neg[s];
      if (sl_phase[s] == PH_FIRST) sl_phase[s] = PH_SECOND;
      else sl_phase[s] = sl_phase[s] - 2'd1;
    end
  endfunction

  function automatic void flash_model(int s);
    logic [8:0] e;
    if (sl_phase[s] == PH_FIRST) begin
      for (int i = 0; i < sl_len[s]; i++) begin
        e = sl_first[s] + 9'(i);
        pal_shown[e] = sl_color[s];
      end
      sl_phase[s] = PH_SECOND;
    end else if (sl_phase[s] == PH_SECOND) begin
      restore_model(s);
      sl_phase[s] = PH_FIRST;
    end
  endfunction

  function automatic engine_resp_t predict_engine(engine_cmd_t c);
    engine_resp_t r;
    int s;
    r = '0;
    s = c.som;
    case (op_t'(c.op))
      OP_LOAD: begin
        pal_base[c.idx] = c.col;
        pal_shown[c.idx] = c.col;
      end
      OP_SETUP: begin
        if (s >= SLOTS || sl_alloc[s]) begin
          r.st = 1;
        end else begin
          sl_color[s] = c.col; sl_first[s] = c.idx; sl_len[s] = c.cnt;
          sl_reload[s] = c.dly; sl_half[s] = c.per; sl_negstart[s] = c.neg;
          sl_phase[s] = PH_IDLE; sl_alloc[s] = 1; sl_steps[s] = 0;
          sl_timer[s] = 0; sl_neg[s] = c.neg;
          r.slot = s[3:0];
        end
      end
      OP_FREE: begin
        if (s >= SLOTS || !sl_alloc[s]) begin
          r.st = 1;
        end else begin
          clear_slot_model(s);
          r.slot = s[3:0];
        end
      end
      OP_START: begin
        running = 1;
        for (int k = 0; k < SLOTS; k++) begin
          if (c.som[k] && sl_alloc[k]) begin
            active_mask[k] = 1;
            sl_phase[k] = PH_FIRST;
          end
        end
      end
      OP_STOP: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (active_mask[k] && sl_alloc[k] && c.som[k]) begin
            restore_model(k);
            sl_phase[k] = PH_IDLE; sl_steps[k] = 0; sl_timer[k] = 0;
            sl_neg[k] = sl_negstart[k];
          end
        end
        if (c.som == 16'hFFFF) begin
          running = 0;
          active_mask = 0;
        end else begin
          active_mask = active_mask & ~c.som;
        end
      end
      OP_TICK: begin
        if (running) begin
          for (int k = 0; k < SLOTS; k++) begin
            if (active_mask[k]) begin
              sl_timer[k] = sl_timer[k] - 8'd1;
              if (sl_timer[k] == 8'hFF) begin
                if (sl_color[k][15]) fade_model(k);
                else flash_model(k);
                sl_timer[k] = sl_reload[k];
              end
            end
          end
        end
      end
      OP_READ: r.rd = pal_shown[c.idx];
      default: ;
    endcase
    return r;
  endfunction

  function automatic engine_cmd_t rand_cmd();
    engine_cmd_t c;
    c.op = 3'($urandom_range(0, 7));
    c.som = 16'($urandom);
    c.idx = 9'($urandom);
    c.col = 16'($urandom);
    c.cnt = 8'($urandom);
    c.dly = 8'($urandom);
    c.per = 5'($urandom);
    c.neg = 1'($urandom);
    return c;
  endfunction

  function automatic engine_cmd_t mk(logic [2:0] op, logic [15:0] som, logic [8:0] idx,
                                     logic [15:0] col, logic [7:0] cnt, logic [7:0] dly,
                                     logic [4:0] per, logic neg);
    engine_cmd_t c;
    c.op = op; c.som = som; c.idx = idx; c.col = col;
    c.cnt = cnt; c.dly = dly; c.per = per; c.neg = neg;
    return c;
  endfunction

  // Driver: after each transfer, in_valid stays low while a random gap counter counts down.
  int gap_in = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_resps.push_back(predict_engine(pending_cmds.pop_front()));
        gap_in <= $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (!in_valid) begin
        if (gap_in > 0) begin
          gap_in <= gap_in - 1;
        end else if (pending_cmds.size() > 0) begin
          operation <= pending_cmds[0].op;
          slot_or_mask <= pending_cmds[0].som;
          palette_index <= pending_cmds[0].idx;
          color <= pending_cmds[0].col;
          entry_count <= pending_cmds[0].cnt;
          tick_delay <= pending_cmds[0].dly;
          step_period <= pending_cmds[0].per;
          start_negative <= pending_cmds[0].neg;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: after every transfer, out_ready stays low while a random gap counter counts down.
  int gap_out = 0;
  always @(posedge clk) begin
    engine_resp_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          $error("result transfer with no prediction waiting");
          errors++;
        end else begin
          want = expected_resps.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0h actual %0h", want.st, status);
            errors++;
          end
          if (slot_number !== want.slot) begin
            $error("slot_number: expected %0h actual %0h", want.slot, slot_number);
            errors++;
          end
          if (read_color !== want.rd) begin
            $error("read_color: expected %0h actual %0h", want.rd, read_color);
            errors++;
          end
        end
        gap_out = $urandom_range(0, 8);
        out_ready <= (gap_out == 0);
      end else if (gap_out > 0) begin
        gap_out--;
        out_ready <= (gap_out == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    engine_cmd_t c;
    int n;
    for (int i = 0; i < ENTRIES; i++) begin
      pal_shown[i] = 0;
      pal_base[i] = 0;
    end
    for (int s = 0; s < SLOTS; s++) clear_slot_model(s);
    active_mask = 0;
    running = 0;

    // Directed part: tick while stopped, field extremes, setups of both
    // modes, a wrapping range, rejections, stop with full and partial masks.
    pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_LOAD, 0, 9'h1FF, 16'hFFFF, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_LOAD, 0, 9'h000, 16'h7C1F, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_LOAD, 0, 9'h001, 16'h0000, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_SETUP, 0, 9'h1FE, 16'h83E0, 4, 0, 0, 1));
    pending_cmds.push_back(mk(OP_SETUP, 0, 0, 0, 1, 0, 0, 0));
    pending_cmds.push_back(mk(OP_SETUP, 16'hFFFF, 0, 0, 1, 0, 0, 0));
    pending_cmds.push_back(mk(OP_SETUP, 15, 9'h010, 16'h7FFF, 8'hFF, 8'hFF, 31, 0));
    pending_cmds.push_back(mk(OP_SETUP, 3, 9'h000, 16'h8000, 2, 1, 1, 0));
    pending_cmds.push_back(mk(OP_FREE, 7, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_FREE, 16'h0010, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_START, 16'hFFFF, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 6; i++) pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_READ, 0, 9'h1FF, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_READ, 0, 9'h000, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_FREE, 3, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_STOP, 16'h0001, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_NONE, 16'hFFFF, 9'h1FF, 16'hFFFF, 8'hFF, 8'hFF, 31, 1));
    pending_cmds.push_back(mk(OP_STOP, 16'hFFFF, 0, 0, 0, 0, 0, 0));

    // Random part: mostly well-formed sessions of loads, setups with short
    // ranges and timers, a start, a burst of ticks and reads, then a stop and a free.
    n = 0;
    while (n < 110) begin
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 4)) begin
          c = rand_cmd(); c.op = OP_LOAD; c.idx[8:5] = $urandom_range(0, 1) ? 4'h0 : 4'hF;
          pending_cmds.push_back(c); n++;
        end
        repeat ($urandom_range(1, 3)) begin
          c = rand_cmd(); c.op = OP_SETUP; c.som = 16'($urandom_range(0, 15));
          if ($urandom_range(0, 9) == 0) c.som = 16'($urandom);
          c.cnt = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 12));
          c.dly = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
          c.per = $urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(0, 3));
          c.idx[8:5] = $urandom_range(0, 1) ? 4'h0 : 4'hF;
          pending_cmds.push_back(c); n++;
        end
        c = rand_cmd(); c.op = OP_START; pending_cmds.push_back(c); n++;
        repeat ($urandom_range(2, 10)) begin
          c = rand_cmd(); c.op = $urandom_range(0, 3) == 0 ? OP_READ : OP_TICK;
          c.idx[8:5] = $urandom_range(0, 1) ? 4'h0 : 4'hF;
          pending_cmds.push_back(c); n++;
        end
        c = rand_cmd(); c.op = OP_STOP;
        if ($urandom_range(0, 1)) c.som = 16'hFFFF;
        pending_cmds.push_back(c); n++;
        c = rand_cmd(); c.op = OP_FREE; c.som = 16'($urandom_range(0, 16));
        pending_cmds.push_back(c); n++;
      end else begin
        c = rand_cmd();
        if (c.op == OP_TICK || c.op == OP_SETUP) c.cnt = 8'($urandom_range(0, 20));
        pending_cmds.push_back(c); n++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    // Drain: all operations sent and every prediction matched, then a short
    // settle so that a stray extra result would still be seen.
    while (pending_cmds.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: palette_flash_engine_top.f
design/pfe_pkg.sv
design/pfe_palette_mem.sv
design/palette_flash_engine_top.sv
sim/tb.sv
